FILE: rtl/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_W       = 32;

  // Bits that can actually carry information (the value field is IN_W wide).
  localparam int VB_EFF     = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;
  localparam bit SIGN_LIVE  = (VALUE_BITS <= IN_W);

  // ceil(VB_EFF * log10(2)) decimal digits, 1233/4096 ~ log10(2).
  localparam int DEC_DIGITS = ((VB_EFF * 1233) >> 12) + 1;
  localparam int HEX_DIGITS = (VB_EFF + 3) / 4;
  localparam int OCT_DIGITS = (VB_EFF + 2) / 3;
  localparam int BIN_DIGITS = VB_EFF;

  // Shift-add-3 work word: BCD digits on top, binary below.
  localparam int WORK_W     = 4 * DEC_DIGITS + VB_EFF;
  localparam int CNT_W      = $clog2(VB_EFF + 1);

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    KIND_HEX = 2'd0,
    KIND_DEC = 2'd1,
    KIND_OCT = 2'd2,
    KIND_BIN = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              neg;
    logic [VB_EFF-1:0] mag;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/itoa_front.sv
`default_nettype none

module itoa_front (
  input  wire logic [1:0]                       in_kind,
  input  wire logic [itoa_pkg::IN_W-1:0]        in_value,
  output itoa_pkg::item_t                       item
);

  logic [itoa_pkg::VB_EFF-1:0] v;
  logic                        neg;

  always_comb begin
    v   = in_value[itoa_pkg::VB_EFF-1:0];
    neg = itoa_pkg::SIGN_LIVE && (itoa_pkg::kind_t'(in_kind) == itoa_pkg::KIND_DEC) &&
          v[itoa_pkg::VB_EFF-1];
    item.kind = itoa_pkg::kind_t'(in_kind);
    item.neg  = neg;
    // two's complement of the most negative value is its own magnitude
    item.mag  = neg ? (~v + itoa_pkg::VB_EFF'(1)) : v;
  end

endmodule

`default_nettype wire

FILE: rtl/itoa_queue.sv
`default_nettype none

module itoa_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire itoa_pkg::item_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output itoa_pkg::item_t      head
);

  itoa_pkg::item_t                 entries_r [itoa_pkg::QDEPTH];
  logic [itoa_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [itoa_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [itoa_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                            do_push, do_pop;

  assign full    = (count_r == itoa_pkg::QCNT_W'(itoa_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign head    = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == itoa_pkg::QPTR_W'(itoa_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + itoa_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == itoa_pkg::QPTR_W'(itoa_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + itoa_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + itoa_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - itoa_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/itoa_back.sv
`default_nettype none

module itoa_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire itoa_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output logic [7:0]           out_char_out,
  output logic                 out_last
);

  localparam int W = itoa_pkg::WORK_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_SKIP = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [W-1:0]                 work_r, work_nxt;
  itoa_pkg::kind_t              kind_r, kind_nxt;
  logic                         neg_r, neg_nxt;
  logic [itoa_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [itoa_pkg::CNT_W-1:0]   iter_r, iter_nxt;
  logic                         ov_r, ov_nxt;
  logic [7:0]                   ch_r, ch_nxt;
  logic                         last_r, last_nxt;

  logic                         slot_free;
  logic [3:0]                   dig;
  logic [7:0]                   dig_char;
  logic [W-1:0]                 work_shift;
  logic [W-1:0]                 adj;
  logic [W-1:0]                 load_work;
  logic [itoa_pkg::CNT_W-1:0]   load_cnt;

  assign slot_free    = !ov_r || out_pop;
  assign out_empty    = !ov_r;
  assign out_char_out = ch_r;
  assign out_last     = last_r;

  always_comb begin
    case (kind_r)
      itoa_pkg::KIND_OCT: begin
        dig        = {1'b0, work_r[W-1 -: 3]};
        work_shift = work_r << 3;
      end
      itoa_pkg::KIND_BIN: begin
        dig        = {3'b000, work_r[W-1]};
        work_shift = work_r << 1;
      end
      default: begin
        dig        = work_r[W-1 -: 4];
        work_shift = work_r << 4;
      end
    endcase
    dig_char = (dig < 4'd10) ? (itoa_pkg::CH_ZERO + {4'b0000, dig})
                             : (itoa_pkg::CH_A + {4'b0000, dig} - 8'd10);
  end

  // shift-add-3: correct every BCD digit of five or more
  always_comb begin
    adj = work_r;
    for (int i = 0; i < itoa_pkg::DEC_DIGITS; i++) begin
      if (work_r[itoa_pkg::VB_EFF + 4*i +: 4] >= 4'd5) begin
        adj[itoa_pkg::VB_EFF + 4*i +: 4] = work_r[itoa_pkg::VB_EFF + 4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    case (q_item.kind)
      itoa_pkg::KIND_HEX: begin
        load_work = W'(q_item.mag) << (W - 4 * itoa_pkg::HEX_DIGITS);
        load_cnt  = itoa_pkg::CNT_W'(itoa_pkg::HEX_DIGITS);
      end
      itoa_pkg::KIND_OCT: begin
        load_work = W'(q_item.mag) << (W - 3 * itoa_pkg::OCT_DIGITS);
        load_cnt  = itoa_pkg::CNT_W'(itoa_pkg::OCT_DIGITS);
      end
      itoa_pkg::KIND_BIN: begin
        load_work = W'(q_item.mag) << (W - itoa_pkg::BIN_DIGITS);
        load_cnt  = itoa_pkg::CNT_W'(itoa_pkg::BIN_DIGITS);
      end
      default: begin
        load_work = W'(q_item.mag);
        load_cnt  = itoa_pkg::CNT_W'(itoa_pkg::DEC_DIGITS);
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    work_nxt  = work_r;
    kind_nxt  = kind_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    iter_nxt  = iter_r;
    ov_nxt    = ov_r && !out_pop;
    ch_nxt    = ch_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          work_nxt = load_work;
          kind_nxt = q_item.kind;
          neg_nxt  = q_item.neg;
          cnt_nxt  = load_cnt;
          iter_nxt = itoa_pkg::CNT_W'(itoa_pkg::VB_EFF);
          if (q_item.kind == itoa_pkg::KIND_DEC) begin
            state_nxt = ST_CONV;
          end else begin
            state_nxt = ST_SKIP;
          end
        end
      end
      ST_CONV: begin
        work_nxt = adj << 1;
        iter_nxt = iter_r - itoa_pkg::CNT_W'(1);
        if (iter_r == itoa_pkg::CNT_W'(1)) begin
          state_nxt = neg_r ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ch_nxt    = itoa_pkg::CH_MINUS;
          last_nxt  = 1'b0;
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (dig == 4'd0 && cnt_r > itoa_pkg::CNT_W'(1)) begin
          work_nxt = work_shift;
          cnt_nxt  = cnt_r - itoa_pkg::CNT_W'(1);
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          ch_nxt   = dig_char;
          last_nxt = (cnt_r == itoa_pkg::CNT_W'(1));
          work_nxt = work_shift;
          cnt_nxt  = cnt_r - itoa_pkg::CNT_W'(1);
          if (cnt_r == itoa_pkg::CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    kind_r <= kind_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    iter_r <= iter_nxt;
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
  end

  a_conv_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (kind_r == itoa_pkg::KIND_DEC &&
                              cnt_r == itoa_pkg::CNT_W'(itoa_pkg::DEC_DIGITS)))
    else $error("conversion running on non-decimal item");

  a_sign_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIGN) |-> (kind_r == itoa_pkg::KIND_DEC && neg_r))
    else $error("minus sign on non-negative item");

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SKIP || state_r == ST_EMIT) |-> (cnt_r != '0))
    else $error("digit count ran out");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && slot_free && cnt_r == itoa_pkg::CNT_W'(1))
      |=> (state_r == ST_IDLE && ov_r && last_r))
    else $error("final character not flagged");

endmodule

`default_nettype wire

FILE: rtl/integer_to_ascii_radix_top.sv
// Hex, octal and binary items skip leading zero digits before the first character;
//   decimal items first run VB_EFF (32) steps of shift-add-3.
// The single digit sequencer converts one item at a time over D digit slots (D = 8, 11, 32
//   in hex/octal/binary, 10 in decimal), plus a '-' for negative decimals.
// A two-entry queue decouples input from conversion; one char per cycle out while popped.
// Reset: synchronous, active low; clears control state only, no clearing pass.
`default_nettype none

module integer_to_ascii_radix_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_push,
  output logic                              in_full,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [itoa_pkg::IN_W-1:0]    in_value,
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output logic [7:0]                        out_char_out,
  output logic                              out_last
);

  itoa_pkg::item_t front_item;
  itoa_pkg::item_t q_head;
  logic            q_empty;
  logic            q_pop;

  itoa_front u_front (
    .in_kind  (in_kind),
    .in_value (in_value),
    .item     (front_item)
  );

  itoa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_item (front_item),
    .full      (in_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  itoa_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_item       (q_head),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire
